/* src/lru_key_value_cache_macros.svh */
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared wrappers for the concurrent checks of the cache RTL.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LRUKV_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LRUKV_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lrukv_pkg.sv */
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, codes and shared types of the cache.
// ---------------------------------------------------------------------------
package lrukv_pkg;

    // Store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Register reset and miss answer
    localparam logic [CFG_W-1:0]         CFG_RESET  = CFG_W'(16);
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

    // Request action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Request handed to the store
    typedef struct packed {
        logic                     put;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_op;

    // Lookup answer from the store
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] value;
    } t_lookup;

endpackage

/* src/lrukv_if.sv */
// ---------------------------------------------------------------------------
// LRU key-value cache channels
// Valid/ready request and response channels of the cache.
// ---------------------------------------------------------------------------

// Request channel: get or put
interface lrukv_req_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic signed [lrukv_pkg::DATA_W-1:0] lookup_key;
    logic signed [lrukv_pkg::DATA_W-1:0] write_value;

    modport source (output valid, action, lookup_key, write_value, input ready);
    modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

// Response channel: get answer
interface lrukv_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic signed [lrukv_pkg::DATA_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

/* src/lru_key_value_cache.sv */
// ---------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  i_req     in         action, lookup_key, write_value
//  o_rsp     out        hit, read_value (get only)
//  i_cfg_*   in         capacity_in_use write
//
// One request per cycle unless stalled: a request is held in the input register while
// the parallel key match and rank update run, and a get answer is then loaded into
// the output register.
// A put gives no response. Reset empties the store and sets the capacity to 16.
// A stalled response holds the output register; puts keep flowing, a get
// waits in the input register until the output register frees.
// ---------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrukv_pkg::CFG_W-1:0]   i_cfg_wdata,
    lrukv_req_if.sink                     i_req,
    lrukv_rsp_if.source                   o_rsp
);

    logic [lrukv_pkg::CFG_W-1:0]          r_capacity;
    logic                                 r_s1_valid;
    lrukv_pkg::t_op                       r_s1_op;
    logic                                 r_out_valid;
    logic                                 r_out_hit;
    logic signed [lrukv_pkg::DATA_W-1:0]  r_out_value;

    logic [lrukv_pkg::CNT_W-1:0]          w_capacity;
    logic                                 w_out_free;
    logic                                 w_go;
    lrukv_pkg::t_lookup                   w_lookup;

    // Clamp the capacity register to 1..ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            w_capacity = lrukv_pkg::CNT_W'(1);
        end else if (lrukv_pkg::CMP_W'(r_capacity) >
                     lrukv_pkg::CMP_W'(lrukv_pkg::ENTRIES)) begin
            w_capacity = lrukv_pkg::CNT_W'(lrukv_pkg::ENTRIES);
        end else begin
            w_capacity = lrukv_pkg::CNT_W'(r_capacity);
        end
    end

    // Advance the held request when it has somewhere to go
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_go        = r_s1_valid && ((r_s1_op.put == lrukv_pkg::ACT_PUT) || w_out_free);
    assign i_req.ready = !r_s1_valid || w_go;

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lrukv_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_op.put   <= (i_req.action == lrukv_pkg::ACT_PUT);
            r_s1_op.key   <= i_req.lookup_key;
            r_s1_op.value <= i_req.write_value;
        end
    end

    lrukv_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_op       (r_s1_op),
        .i_capacity (w_capacity),
        .o_lookup   (w_lookup)
    );

    // Output register control: load a get answer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && !r_s1_op.put) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_go && !r_s1_op.put) begin
            r_out_hit   <= w_lookup.hit;
            r_out_value <= w_lookup.value;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_value;

endmodule

/* src/lrukv_store.sv */
// ---------------------------------------------------------------------------
// LRU key-value store
// Fully associative entries with parallel key match and recency ranks.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lrukv_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  lrukv_pkg::t_op                i_op,
    input  logic [lrukv_pkg::CNT_W-1:0]   i_capacity,
    output lrukv_pkg::t_lookup            o_lookup
);

    // Entry state
    logic [lrukv_pkg::ENTRIES-1:0]        r_valid;
    logic signed [lrukv_pkg::DATA_W-1:0]  r_key   [lrukv_pkg::ENTRIES];
    logic signed [lrukv_pkg::DATA_W-1:0]  r_value [lrukv_pkg::ENTRIES];
    logic [lrukv_pkg::IDX_W-1:0]          r_rank  [lrukv_pkg::ENTRIES];
    logic [lrukv_pkg::CNT_W-1:0]          r_occupied;

    logic [lrukv_pkg::ENTRIES-1:0]        w_match;
    logic                                 w_hit;
    logic signed [lrukv_pkg::DATA_W-1:0]  w_hit_value;
    logic [lrukv_pkg::IDX_W-1:0]          w_hit_rank;
    logic                                 w_evict;
    logic [lrukv_pkg::ENTRIES-1:0]        w_keep;
    logic                                 w_free_found;
    logic [lrukv_pkg::IDX_W-1:0]          w_slot;
    logic [lrukv_pkg::ENTRIES-1:0]        w_slot_sel;

    // Match all entries, pick the lowest free slot after eviction
    always_comb begin
        w_hit_value = '0;
        w_hit_rank  = '0;
        w_slot      = '0;
        w_slot_sel  = '0;
        for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == i_op.key);
        end
        w_hit = |w_match;
        // At most one entry matches, so OR the selected fields together
        for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_value = w_hit_value | r_value[i];
                w_hit_rank  = w_hit_rank | r_rank[i];
            end
        end
        w_evict = (r_occupied >= i_capacity);
        for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
            w_keep[i] = r_valid[i] &&
                !(w_evict && (lrukv_pkg::CNT_W'(r_rank[i]) >=
                              (i_capacity - lrukv_pkg::CNT_W'(1))));
        end
        w_free_found = !(&w_keep);
        for (int i = lrukv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!w_keep[i]) begin
                w_slot = lrukv_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
            w_slot_sel[i] = w_free_found && (w_slot == lrukv_pkg::IDX_W'(i));
        end
    end

    assign o_lookup.hit   = w_hit;
    assign o_lookup.value = w_hit ? w_hit_value : lrukv_pkg::MISS_VALUE;

    // Update valid bits, ranks and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_occupied <= '0;
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_go) begin
            if (w_hit) begin
                // Promote the matching entry, age the more recent ones
                for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                    if (w_match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + lrukv_pkg::IDX_W'(1);
                    end
                end
            end else if (i_op.put) begin
                // Drop the oldest entries if full, age the rest, insert
                r_valid <= w_keep | w_slot_sel;
                for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                    if (w_slot_sel[i]) begin
                        r_rank[i] <= '0;
                    end else if (w_keep[i]) begin
                        r_rank[i] <= r_rank[i] + lrukv_pkg::IDX_W'(1);
                    end
                end
                r_occupied <= w_evict ? i_capacity
                                      : r_occupied + lrukv_pkg::CNT_W'(1);
            end
        end
    end

    // Write key and value of the touched entry
    always_ff @(posedge i_clk) begin
        if (i_go && i_op.put) begin
            for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
                if (w_hit) begin
                    if (w_match[i]) begin
                        r_value[i] <= i_op.value;
                    end
                end else if (w_slot_sel[i]) begin
                    r_key[i]   <= i_op.key;
                    r_value[i] <= i_op.value;
                end
            end
        end
    end

    `LRUKV_ASSERT(a_match_unique, i_clk, i_rst_n, $onehot0(w_match), "key matches two entries")
    `LRUKV_ASSERT(a_count_tracks, i_clk, i_rst_n, $countones(r_valid) == r_occupied, "occupancy differs from valid bits")
    `LRUKV_ASSERT(a_count_bound, i_clk, i_rst_n, r_occupied <= lrukv_pkg::CNT_W'(lrukv_pkg::ENTRIES), "occupancy above store size")
    `LRUKV_ASSERT(a_insert_lands, i_clk, i_rst_n, (i_go && i_op.put && !w_hit) |=> (r_valid != '0), "insert left store empty")

endmodule
